@@ rtl/core/tlbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, sizes, reset values and controller states of the TLB and
// page table address translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int ADDR_W    = 22;
    localparam int FRAME_W   = 10;
    localparam int FC_W      = 11;
    localparam int FCNT_W    = 32;

    localparam int VIRTUAL_PAGES = 1024;
    localparam int PAGE_BYTES    = 4096;

    localparam logic [FC_W-1:0] FC_RESET = 11'd1024;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_MODF,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/tlbpt_mod_unit.sv @@
// ----------------------------------------------------------------------------
// tlbpt_mod_unit
// Restoring remainder unit: one dividend bit per cycle, one-cycle done
// pulse with the remainder held until next start.
// ----------------------------------------------------------------------------
module tlbpt_mod_unit #(
    parameter int DIVD_W = 10,
    parameter int DIVS_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVS_W-1:0] o_remainder
);

    localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_dvd;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DIVD_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = DIVS_W'(shifted - {1'b0, r_dvs});
        end else begin
            n_rem = DIVS_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

@@ rtl/core/tlb_page_table_translator.sv @@
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical address translation through a fully associative TLB
// backed by a page table memory, with fault fill and FIFO TLB refill.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. After reset the page table memory is
// swept to invalid, one entry per cycle, across all VIRTUAL_PAGES entries;
// no transaction is taken during the sweep. A TLB hit goes straight from
// lookup to the output step; a miss adds a read of the page table memory
// and a TLB refill, and a fault also writes the entry back. A fault whose
// page is not below the frame count also passes through the bit-serial
// remainder unit. The result sits in an output register, so a stalled
// consumer holds only the last step of the following transaction.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tlbpt_pkg::FC_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0]  i_virtual_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlbpt_pkg::ADDR_W-1:0]  o_physical_address,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault,
    output logic [tlbpt_pkg::FCNT_W-1:0]  o_fault_total
);

    import tlbpt_pkg::*;

    localparam int OFS_W  = $clog2(PAGE_BYTES);
    localparam int RAW_W  = ADDR_W - OFS_W;
    localparam int PG_W   = $clog2(VIRTUAL_PAGES);
    localparam int TE_W   = $clog2(TLB_ENTRIES);
    localparam int CMP_W  = (PG_W > FRAME_W) ? PG_W : FRAME_W;
    localparam int DIVD_W = PG_W;
    localparam int DIVS_W = FC_W;

    t_state r_state;
    t_state n_state;

    logic [FC_W-1:0]    r_frame_count;
    logic [FC_W-1:0]    fc_eff;

    logic [PG_W-1:0]    r_clr;
    logic [PG_W-1:0]    r_page;
    logic [OFS_W-1:0]   r_offset;
    logic [FRAME_W-1:0] r_frame;
    logic               r_hit;
    logic               r_fault;
    logic [FCNT_W-1:0]  r_fault_cnt;

    logic [FRAME_W-1:0] r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0] r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TE_W-1:0]    r_fill;

    logic [FRAME_W:0]   r_pt_mem [VIRTUAL_PAGES];
    logic [FRAME_W:0]   r_pt_rdata;
    logic [PG_W-1:0]    pt_addr;
    logic               pt_we;
    logic [FRAME_W:0]   pt_wdata;

    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_phys;
    logic               r_out_hit;
    logic               r_out_fault;
    logic [FCNT_W-1:0]  r_out_total;

    logic [RAW_W-1:0]   raw_page;
    logic               page_below_fc;
    logic               look_hit;
    logic [FRAME_W-1:0] look_frame;

    logic               mod_start;
    logic [DIVD_W-1:0]  mod_dividend;
    logic [DIVS_W-1:0]  mod_divisor;
    logic               mod_done;
    logic [DIVS_W-1:0]  mod_rem;

    logic               out_free;

    assign raw_page      = i_virtual_address[ADDR_W-1:OFS_W];
    assign fc_eff        = (r_frame_count == '0) ? FC_W'(1) : r_frame_count;
    assign page_below_fc = 32'(r_page) < 32'(fc_eff);
    assign out_free      = !r_out_valid || i_out_ready;

    // lowest matching valid entry wins
    always_comb begin
        look_hit   = 1'b0;
        look_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (CMP_W'(r_tlb_page[i]) == CMP_W'(r_page))) begin
                look_hit   = 1'b1;
                look_frame = r_tlb_frame[i];
            end
        end
    end

    tlbpt_mod_unit #(
        .DIVD_W (DIVD_W),
        .DIVS_W (DIVS_W)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (mod_dividend),
        .i_divisor   (mod_divisor),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        mod_start    = 1'b0;
        mod_dividend = DIVD_W'(r_page);
        mod_divisor  = DIVS_W'(fc_eff);
        pt_we        = 1'b0;
        pt_addr      = r_page;
        pt_wdata     = {1'b1, r_frame};
        case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_addr  = r_clr;
                pt_wdata = '0;
                if (r_clr == PG_W'(VIRTUAL_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = look_hit ? S_DONE : S_READ;
            end
            S_READ: begin
                if (r_pt_rdata[FRAME_W] || page_below_fc) begin
                    n_state = S_UPDATE;
                end else begin
                    mod_start = 1'b1;
                    n_state   = S_MODF;
                end
            end
            S_MODF: begin
                if (mod_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                pt_we   = r_fault;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_addr] <= pt_wdata;
        end
        r_pt_rdata <= r_pt_mem[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FC_RESET;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_offset <= i_virtual_address[OFS_W-1:0];
                r_page   <= PG_W'(raw_page);
            end
            S_LOOKUP: begin
                r_hit   <= look_hit;
                r_frame <= look_frame;
                r_fault <= 1'b0;
            end
            S_READ: begin
                if (r_pt_rdata[FRAME_W]) begin
                    r_frame <= r_pt_rdata[FRAME_W-1:0];
                end else begin
                    r_fault <= 1'b1;
                    r_frame <= FRAME_W'(r_page);
                end
            end
            S_MODF: begin
                if (mod_done) begin
                    r_frame <= FRAME_W'(mod_rem);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_tlb_page[r_fill]  <= FRAME_W'(r_page);
            r_tlb_frame[r_fill] <= r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid <= '0;
            r_fill      <= '0;
            r_fault_cnt <= '0;
        end else if (r_state == S_UPDATE) begin
            r_tlb_valid[r_fill] <= 1'b1;
            r_fill <= (r_fill == TE_W'(TLB_ENTRIES - 1)) ? '0 : r_fill + 1'b1;
            if (r_fault && (r_fault_cnt != '1)) begin
                r_fault_cnt <= r_fault_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_phys      <= ADDR_W'({r_frame, r_offset});
            r_out_hit   <= r_hit;
            r_out_fault <= r_fault;
            r_out_total <= r_fault_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_fault_total      = r_out_total;

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("transaction reports both TLB hit and page fault");

    a_pt_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_we |-> ((r_state == S_CLEAR) || r_fault))
        else $error("page table written outside clear or fault fill");

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && r_fault && (r_fault_cnt != '1))
        |=> (r_fault_cnt == $past(r_fault_cnt) + 1'b1))
        else $error("fault counter did not advance on fault");

endmodule
